>>> rtl/vlc_block_coefficient_decoder_unit_macros.svh
// Assertion macros shared by the RTL of the coefficient decoder.
// They expect the module to have a clock named clock and an active-high reset named reset.
`ifndef VLC_BLOCK_COEFFICIENT_DECODER_UNIT_MACROS_SVH
`define VLC_BLOCK_COEFFICIENT_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VBCD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VBCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/vbcd_pkg.sv
package vbcd_pkg;

   // Queue depths on the byte side and on the result side.
   localparam int IN_DEPTH  = 2;
   localparam int OUT_DEPTH = 4;

   // Macroblock layout.
   localparam logic [2:0] BLOCKS_PER_MB = 3'd6;
   localparam logic [2:0] LUMA_BLOCKS   = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_COEF = 2'd0;
   localparam logic [1:0] KIND_SKIP = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // One bitstream byte as it waits in the input queue.
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       final_byte;
   } vbcd_in_type;

   // One result beat.
   typedef struct packed {
      logic [1:0]         item_kind;
      logic [6:0]         macroblock_number;
      logic [2:0]         block_number;
      logic [5:0]         coef_number;
      logic signed [8:0]  coef_value;
      logic signed [17:0] luma_dc_sum;
      logic               last_of_run;
   } vbcd_result_type;

endpackage

>>> rtl/vbcd_fifo.sv
`include "vlc_block_coefficient_decoder_unit_macros.svh"

module vbcd_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_data,
   input  logic     rd_en,
   output item_type rd_data,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Status and head of the queue.
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only written entries are ever read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `VBCD_ASSERT_IMPLY(a_no_write_when_full, wr_en, count_ff != CNT_W'(DEPTH), "write to a full queue")
   `VBCD_ASSERT_IMPLY(a_no_read_when_empty, rd_en, count_ff != '0, "read from an empty queue")
   `VBCD_ASSERT_NEXT(a_fill_tracks_write, wr_en && !rd_en, count_ff != '0, "fill level lost a write")

endmodule

>>> rtl/vbcd_engine.sv
`include "vlc_block_coefficient_decoder_unit_macros.svh"

module vbcd_engine #(
   parameter int MB_COLS         = 8,
   parameter int MB_ROWS         = 9,
   parameter int COEFS_PER_BLOCK = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [1:0]                csr_pattern_mode,
   input  logic                      in_empty,
   input  vbcd_pkg::vbcd_in_type     in_item,
   output logic                      in_pop,
   input  logic                      out_full,
   output logic                      out_push,
   output vbcd_pkg::vbcd_result_type out_item
);

   import vbcd_pkg::*;

   localparam int MB_TOTAL = MB_COLS * MB_ROWS;
   localparam int MB_W     = $clog2(MB_TOTAL + 1);
   localparam logic [5:0] COEF_LAST = 6'(COEFS_PER_BLOCK - 1);

   // Parse phases.
   localparam logic [1:0] PH_HEAD   = 2'd0;
   localparam logic [1:0] PH_DECIDE = 2'd1;
   localparam logic [1:0] PH_PREFIX = 2'd2;
   localparam logic [1:0] PH_AMP    = 2'd3;

   // Coded-pattern modes.
   localparam logic [1:0] MODE_BLOCK   = 2'd0;
   localparam logic [1:0] MODE_MB      = 2'd1;
   localparam logic [1:0] MODE_PATTERN = 2'd2;

   logic [1:0]      pattern_mode_ff;
   logic [1:0]      phase_ff, phase_in;
   logic [2:0]      prefix_ff, prefix_in;
   logic [3:0]      size_ff, size_in;
   logic [7:0]      amp_acc_ff, amp_acc_in;
   logic [3:0]      amp_left_ff, amp_left_in;
   logic [5:0]      pattern_ff, pattern_in;
   logic [2:0]      pat_cnt_ff, pat_cnt_in;
   logic [1:0]      mode_now_ff, mode_now_in;
   logic [5:0]      coef_cnt_ff, coef_cnt_in;
   logic [2:0]      blk_cnt_ff, blk_cnt_in;
   logic [MB_W-1:0] mb_cnt_ff, mb_cnt_in;
   logic [17:0]     dc_ff, dc_in;
   logic            fdone_ff, fdone_in;
   logic [3:0]      bit_idx_ff, bit_idx_in;
   logic            finish_ff, finish_in;

   vbcd_result_type hold_ff, hold_in;
   logic            hold_valid_ff, hold_valid_in;
   logic            hold_last_ff, hold_last_in;

   logic            step_en, cur_bit, cbit;
   logic            sel_decide, sel_bit, sel_zero, sel_end;
   logic            coef_step, head_step;
   logic            size_hit, fin_hit, adv_hit, skip_hit, start_hit;
   logic [3:0]      size_val;
   logic signed [8:0] fin_val;
   logic [2:0]      adv_from, blk_inc;
   logic [7:0]      acc_n;
   logic [3:0]      left_n, s_cl;
   logic [8:0]      thr;
   logic [9:0]      neg_val;
   logic [MB_W-1:0] mb_inc;
   logic            byte_end;
   logic            em_valid;
   vbcd_result_type em;
   logic            new_res, mark;

   // One step per cycle while a byte waits and the result queue has room.
   assign step_en = !in_empty && !out_full;
   assign in_pop  = step_en && byte_end;

   // Bit-serial decode step.
   always_comb begin
      phase_in    = phase_ff;
      prefix_in   = prefix_ff;
      size_in     = size_ff;
      amp_acc_in  = amp_acc_ff;
      amp_left_in = amp_left_ff;
      pattern_in  = pattern_ff;
      pat_cnt_in  = pat_cnt_ff;
      mode_now_in = mode_now_ff;
      coef_cnt_in = coef_cnt_ff;
      blk_cnt_in  = blk_cnt_ff;
      mb_cnt_in   = mb_cnt_ff;
      dc_in       = dc_ff;
      fdone_in    = fdone_ff;
      bit_idx_in  = bit_idx_ff;
      finish_in   = finish_ff;
      size_hit    = 1'b0;
      fin_hit     = 1'b0;
      adv_hit     = 1'b0;
      skip_hit    = 1'b0;
      start_hit   = 1'b0;
      size_val    = 4'd0;
      fin_val     = '0;
      adv_from    = blk_cnt_ff;
      blk_inc     = 3'd0;
      mb_inc      = mb_cnt_ff + 1'b1;
      left_n      = amp_left_ff;
      s_cl        = size_ff;
      thr         = 9'd0;
      neg_val     = 10'd0;
      byte_end    = 1'b0;
      em_valid    = 1'b0;
      em          = '0;

      // Pick what this cycle does: resolve a pattern bit, take a stream bit,
      // pad a begun code with a zero, or close the frame.
      sel_decide = !finish_ff && !fdone_ff && (phase_ff == PH_DECIDE);
      sel_bit    = !finish_ff && !sel_decide && !fdone_ff && !bit_idx_ff[3];
      sel_zero   = finish_ff && !fdone_ff &&
                   (((phase_ff == PH_PREFIX) && (prefix_ff != 3'd0)) || (phase_ff == PH_AMP));
      sel_end    = finish_ff && !sel_zero;
      cur_bit    = in_item.stream_byte[3'd7 - bit_idx_ff[2:0]];
      cbit       = sel_bit && cur_bit;
      coef_step  = (sel_bit && ((phase_ff == PH_PREFIX) || (phase_ff == PH_AMP))) || sel_zero;
      head_step  = sel_bit && (phase_ff == PH_HEAD);
      acc_n      = {amp_acc_ff[6:0], cbit};
      if (sel_bit) begin
         bit_idx_in = bit_idx_ff + 1'b1;
      end

      // Block flag, macroblock flag or pattern bit.
      if (head_step) begin
         if ((blk_cnt_ff == 3'd0) && (pat_cnt_ff == 3'd0)) begin
            mode_now_in = (pattern_mode_ff == MODE_BLOCK || pattern_mode_ff == MODE_MB ||
                           pattern_mode_ff == MODE_PATTERN) ? pattern_mode_ff : MODE_BLOCK;
         end
         case (mode_now_in)
            MODE_BLOCK: begin
               if (cbit) begin
                  start_hit = 1'b1;
               end else begin
                  skip_hit = 1'b1;
                  adv_hit  = 1'b1;
               end
            end
            MODE_MB: begin
               if (cbit) begin
                  pattern_in = 6'h3F;
                  phase_in   = PH_DECIDE;
               end else begin
                  skip_hit = 1'b1;
                  adv_from = BLOCKS_PER_MB - 3'd1;
                  adv_hit  = 1'b1;
               end
            end
            default: begin
               pattern_in = {pattern_ff[4:0], cbit};
               pat_cnt_in = pat_cnt_ff + 1'b1;
               if (pat_cnt_in == BLOCKS_PER_MB) begin
                  pat_cnt_in = 3'd0;
                  phase_in   = PH_DECIDE;
               end
            end
         endcase
      end

      // One block of the pattern is resolved per cycle while the engine can step.
      if (sel_decide) begin
         if (pattern_ff[3'd5 - blk_cnt_ff]) begin
            start_hit = 1'b1;
         end else begin
            skip_hit = 1'b1;
            adv_hit  = 1'b1;
         end
      end

      // Size prefix tree and amplitude bits.
      if (coef_step) begin
         if (phase_ff == PH_PREFIX) begin
            case (prefix_ff)
               3'd0: prefix_in = cbit ? 3'd2 : 3'd1;
               3'd1: begin
                  size_hit = 1'b1;
                  size_val = cbit ? 4'd2 : 4'd1;
               end
               3'd2: prefix_in = cbit ? 3'd4 : 3'd3;
               3'd3: begin
                  size_hit = 1'b1;
                  size_val = cbit ? 4'd3 : 4'd0;
               end
               3'd4, 3'd5, 3'd6: begin
                  if (cbit) begin
                     prefix_in = prefix_ff + 1'b1;
                  end else begin
                     size_hit = 1'b1;
                     size_val = {1'b0, prefix_ff};
                  end
               end
               default: begin
                  size_hit = 1'b1;
                  size_val = cbit ? 4'd8 : 4'd7;
               end
            endcase
         end else begin
            amp_acc_in = acc_n;
            if (amp_left_ff != 4'd0) begin
               left_n = amp_left_ff - 4'd1;
            end
            amp_left_in = left_n;
            if (left_n == 4'd0) begin
               // Amplitudes below half the range are negative.
               if (size_ff < 4'd1) begin
                  s_cl = 4'd1;
               end else if (size_ff > 4'd8) begin
                  s_cl = 4'd8;
               end
               thr     = 9'd1 << (s_cl - 4'd1);
               neg_val = {2'b00, acc_n} - (10'd1 << s_cl) + 10'd1;
               fin_hit = 1'b1;
               fin_val = ({1'b0, acc_n} < thr) ? neg_val[8:0] : {1'b0, acc_n};
            end
         end
      end

      if (size_hit) begin
         if (size_val == 4'd0) begin
            fin_hit = 1'b1;
            fin_val = '0;
         end else begin
            size_in     = size_val;
            amp_acc_in  = 8'd0;
            amp_left_in = size_val;
            phase_in    = PH_AMP;
         end
      end

      if (start_hit) begin
         phase_in    = PH_PREFIX;
         prefix_in   = 3'd0;
         coef_cnt_in = 6'd0;
      end

      if (skip_hit) begin
         em_valid             = 1'b1;
         em.item_kind         = KIND_SKIP;
         em.macroblock_number = 7'(mb_cnt_ff);
         em.block_number      = blk_cnt_ff;
         em.luma_dc_sum       = dc_ff;
      end

      // Finished coefficient; the first one of a luma block feeds the DC sum.
      if (fin_hit) begin
         if ((blk_cnt_ff < LUMA_BLOCKS) && (coef_cnt_ff == 6'd0)) begin
            dc_in = dc_ff + {{9{fin_val[8]}}, fin_val};
         end
         em_valid             = 1'b1;
         em.item_kind         = KIND_COEF;
         em.macroblock_number = 7'(mb_cnt_ff);
         em.block_number      = blk_cnt_ff;
         em.coef_number       = coef_cnt_ff;
         em.coef_value        = fin_val;
         em.luma_dc_sum       = dc_in;
         coef_cnt_in          = coef_cnt_ff + 1'b1;
         if (coef_cnt_ff == COEF_LAST) begin
            adv_hit = 1'b1;
         end else begin
            phase_in  = PH_PREFIX;
            prefix_in = 3'd0;
         end
      end

      // Move to the next block, and to the next macroblock after the sixth.
      if (adv_hit) begin
         blk_inc = adv_from + 1'b1;
         if (blk_inc >= BLOCKS_PER_MB) begin
            blk_cnt_in = 3'd0;
            mb_cnt_in  = mb_inc;
            if (mb_inc >= MB_W'(MB_TOTAL)) begin
               fdone_in = 1'b1;
            end
            phase_in   = PH_HEAD;
            pat_cnt_in = 3'd0;
         end else begin
            blk_cnt_in = blk_inc;
            phase_in   = (mode_now_in == MODE_BLOCK) ? PH_HEAD : PH_DECIDE;
         end
      end

      // End of frame: report, then restart the position and the sum.
      if (sel_end) begin
         em_valid       = 1'b1;
         em.item_kind   = KIND_END;
         em.luma_dc_sum = dc_ff;
         phase_in       = PH_HEAD;
         prefix_in      = 3'd0;
         size_in        = 4'd0;
         amp_acc_in     = 8'd0;
         amp_left_in    = 4'd0;
         pattern_in     = 6'd0;
         pat_cnt_in     = 3'd0;
         mode_now_in    = MODE_BLOCK;
         coef_cnt_in    = 6'd0;
         blk_cnt_in     = 3'd0;
         mb_cnt_in      = '0;
         dc_in          = 18'd0;
         fdone_in       = 1'b0;
      end

      // Byte bookkeeping: done with the bits once no pattern work is left.
      if (!finish_ff) begin
         if (fdone_in || (bit_idx_in[3] && (phase_in != PH_DECIDE))) begin
            if (in_item.final_byte) begin
               finish_in = 1'b1;
            end else begin
               byte_end = 1'b1;
            end
         end
      end else if (sel_end) begin
         byte_end  = 1'b1;
         finish_in = 1'b0;
      end
      if (byte_end) begin
         bit_idx_in = 4'd0;
      end
   end

   // Hold stage: a result leaves once the next one exists or the byte is over,
   // so the last beat of each byte can be marked.
   assign new_res  = step_en && em_valid;
   assign mark     = step_en && byte_end;
   assign out_push = hold_valid_ff && (hold_last_ff || new_res) && !out_full;

   always_comb begin
      out_item             = hold_ff;
      out_item.last_of_run = hold_last_ff;
   end

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      hold_last_in  = hold_last_ff;
      if (out_push) begin
         hold_valid_in = 1'b0;
         hold_last_in  = 1'b0;
      end
      if (new_res) begin
         hold_in       = em;
         hold_valid_in = 1'b1;
         hold_last_in  = mark;
      end else if (mark && hold_valid_ff && !out_push) begin
         hold_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_mode_ff <= MODE_BLOCK;
         phase_ff        <= PH_HEAD;
         prefix_ff       <= 3'd0;
         size_ff         <= 4'd0;
         amp_acc_ff      <= 8'd0;
         amp_left_ff     <= 4'd0;
         pattern_ff      <= 6'd0;
         pat_cnt_ff      <= 3'd0;
         mode_now_ff     <= MODE_BLOCK;
         coef_cnt_ff     <= 6'd0;
         blk_cnt_ff      <= 3'd0;
         mb_cnt_ff       <= '0;
         dc_ff           <= 18'd0;
         fdone_ff        <= 1'b0;
         bit_idx_ff      <= 4'd0;
         finish_ff       <= 1'b0;
         hold_valid_ff   <= 1'b0;
         hold_last_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            pattern_mode_ff <= csr_pattern_mode;
         end
         if (step_en) begin
            phase_ff    <= phase_in;
            prefix_ff   <= prefix_in;
            size_ff     <= size_in;
            amp_acc_ff  <= amp_acc_in;
            amp_left_ff <= amp_left_in;
            pattern_ff  <= pattern_in;
            pat_cnt_ff  <= pat_cnt_in;
            mode_now_ff <= mode_now_in;
            coef_cnt_ff <= coef_cnt_in;
            blk_cnt_ff  <= blk_cnt_in;
            mb_cnt_ff   <= mb_cnt_in;
            dc_ff       <= dc_in;
            fdone_ff    <= fdone_in;
            bit_idx_ff  <= bit_idx_in;
            finish_ff   <= finish_in;
         end
         hold_valid_ff <= hold_valid_in;
         hold_last_ff  <= hold_last_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   `VBCD_ASSERT_IMPLY(a_last_needs_hold, hold_last_ff, hold_valid_ff, "last mark without a held result")
   `VBCD_ASSERT_IMPLY(a_block_range, 1'b1, blk_cnt_ff <= 3'd5, "block counter out of range")
   `VBCD_ASSERT_IMPLY(a_amp_pending, phase_ff == PH_AMP, amp_left_ff != 4'd0, "amplitude phase with no bits left")
   `VBCD_ASSERT_IMPLY(a_end_closes_byte, step_en && sel_end, byte_end, "end of frame did not close the byte")
   `VBCD_ASSERT_NEXT(a_end_restarts, step_en && sel_end, mb_cnt_ff == '0 && dc_ff == 18'd0 && !finish_ff, "frame restart incomplete")

endmodule

>>> rtl/vlc_block_coefficient_decoder_unit.sv
// Coefficient decoder: takes a frame's bitstream one byte per beat and returns one beat per
// decoded coefficient, skipped block or macroblock, and end of frame. The decode engine consumes
// one bitstream bit per cycle while a byte waits and the result queue has room; it also spends
// steps on blocks skipped by a coded pattern, on zero bits that finish a code begun in the final
// byte of a frame and on the end-of-frame beat, and closes a byte that arrives after the grid is
// complete without decoding its bits. A two-beat byte queue in front and a four-beat result queue
// behind let either side stall without stopping the other. A result is held back in a hold stage
// until it is known whether it is the last beat caused by its byte, which is when last_of_run is
// set. The pattern mode register may be written whenever the block is idle.
module vlc_block_coefficient_decoder_unit #(
   parameter int MB_COLS         = 8,
   parameter int MB_ROWS         = 9,
   parameter int COEFS_PER_BLOCK = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_stream_byte,
   input  logic               req_final_byte,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_item_kind,
   output logic [6:0]         rsp_macroblock_number,
   output logic [2:0]         rsp_block_number,
   output logic [5:0]         rsp_coef_number,
   output logic signed [8:0]  rsp_coef_value,
   output logic signed [17:0] rsp_luma_dc_sum,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_pattern_mode
);

   import vbcd_pkg::*;

   vbcd_in_type     in_wr_data, in_head;
   logic            in_wr, in_empty, in_pop;
   vbcd_result_type out_item, rsp_head;
   logic            out_push, out_full, rsp_rd;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   // Front: accepted bytes wait in a short queue.
   assign in_wr                  = push && !full;
   assign in_wr_data.stream_byte = req_stream_byte;
   assign in_wr_data.final_byte  = req_final_byte;

   vbcd_fifo #(
      .item_type (vbcd_in_type),
      .DEPTH     (IN_DEPTH)
   ) u_in_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (in_wr),
      .wr_data (in_wr_data),
      .rd_en   (in_pop),
      .rd_data (in_head),
      .full    (full),
      .empty   (in_empty)
   );

   // Back: bit-serial decode engine.
   vbcd_engine #(
      .MB_COLS         (MB_COLS),
      .MB_ROWS         (MB_ROWS),
      .COEFS_PER_BLOCK (COEFS_PER_BLOCK)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_pattern_mode (csr_pattern_mode),
      .in_empty         (in_empty),
      .in_item          (in_head),
      .in_pop           (in_pop),
      .out_full         (out_full),
      .out_push         (out_push),
      .out_item         (out_item)
   );

   // Result queue toward the consumer.
   assign rsp_rd = pop && !empty;

   vbcd_fifo #(
      .item_type (vbcd_result_type),
      .DEPTH     (OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_item),
      .rd_en   (rsp_rd),
      .rd_data (rsp_head),
      .full    (out_full),
      .empty   (empty)
   );

   // Oldest result beat on the ports.
   assign rsp_item_kind         = rsp_head.item_kind;
   assign rsp_macroblock_number = rsp_head.macroblock_number;
   assign rsp_block_number      = rsp_head.block_number;
   assign rsp_coef_number       = rsp_head.coef_number;
   assign rsp_coef_value        = rsp_head.coef_value;
   assign rsp_luma_dc_sum       = rsp_head.luma_dc_sum;
   assign rsp_last_of_run       = rsp_head.last_of_run;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import vbcd_pkg::*;

   localparam int MB_COLS         = 8;
   localparam int MB_ROWS         = 9;
   localparam int COEFS_PER_BLOCK = 64;
   localparam int MB_TOTAL        = MB_COLS * MB_ROWS;
   localparam int MAX_BEATS       = 16;
   localparam int RANDOM_BYTES    = 330;
   localparam int STEADY_AFTER    = 270;
   localparam int SETTLE_CYCLES   = 100;
   localparam int CYCLE_LIMIT     = 500000;

   // Values of the pattern mode register.
   localparam logic [1:0] MODE_BLOCK_FLAG = 2'd0;
   localparam logic [1:0] MODE_MB_FLAG    = 2'd1;
   localparam logic [1:0] MODE_PATTERN    = 2'd2;
   localparam logic [1:0] MODE_ALIAS      = 2'd3;

   typedef enum logic [1:0] {AT_HEADER, AT_DECIDE, AT_PREFIX, AT_AMPLITUDE} parse_state_e;

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   logic [7:0]         req_stream_byte;
   logic               req_final_byte;
   logic               empty;
   logic               pop;
   logic [1:0]         rsp_item_kind;
   logic [6:0]         rsp_macroblock_number;
   logic [2:0]         rsp_block_number;
   logic [5:0]         rsp_coef_number;
   logic signed [8:0]  rsp_coef_value;
   logic signed [17:0] rsp_luma_dc_sum;
   logic               rsp_last_of_run;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_pattern_mode;

   vlc_block_coefficient_decoder_unit #(
      .MB_COLS(MB_COLS),
      .MB_ROWS(MB_ROWS),
      .COEFS_PER_BLOCK(COEFS_PER_BLOCK)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_stream_byte(req_stream_byte),
      .req_final_byte(req_final_byte),
      .empty(empty),
      .pop(pop),
      .rsp_item_kind(rsp_item_kind),
      .rsp_macroblock_number(rsp_macroblock_number),
      .rsp_block_number(rsp_block_number),
      .rsp_coef_number(rsp_coef_number),
      .rsp_coef_value(rsp_coef_value),
      .rsp_luma_dc_sum(rsp_luma_dc_sum),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_pattern_mode(csr_pattern_mode)
   );

   // Decoder state as the testbench predicts it.
   logic [1:0]         mode_setting;
   logic [1:0]         mb_mode;
   parse_state_e       parse_state;
   logic [2:0]         tree_node;
   logic [3:0]         amp_size;
   logic [3:0]         amp_left;
   logic [7:0]         amp_bits;
   logic [5:0]         coded_mask;
   logic [2:0]         mask_count;
   logic [6:0]         coef_idx;
   logic [2:0]         blk_idx;
   logic [6:0]         mb_idx;
   logic signed [17:0] dc_sum;
   logic               grid_full;

   vbcd_result_type byte_beats[$];
   vbcd_result_type awaited_beats[$];
   bit              stream_bits[$];

   int error_count = 0;
   int cycle_count = 0;
   int bytes_sent  = 0;
   bit steady_flow = 1'b0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void restart_frame();
      parse_state = AT_HEADER;
      tree_node   = '0;
      amp_size    = '0;
      amp_bits    = '0;
      amp_left    = '0;
      coded_mask  = '0;
      coef_idx    = '0;
      blk_idx     = '0;
      mb_idx      = '0;
      dc_sum      = '0;
      grid_full   = 1'b0;
      mb_mode     = MODE_BLOCK_FLAG;
      mask_count  = '0;
   endfunction

   function automatic void add_beat(input logic [1:0] kind, input logic [5:0] coef,
                                    input logic signed [8:0] value);
      vbcd_result_type beat;
      if (byte_beats.size() >= MAX_BEATS) return;
      beat.item_kind         = kind;
      beat.macroblock_number = (kind == KIND_END) ? '0 : mb_idx;
      beat.block_number      = (kind == KIND_END) ? '0 : blk_idx;
      beat.coef_number       = coef;
      beat.coef_value        = value;
      beat.luma_dc_sum       = dc_sum;
      beat.last_of_run       = 1'b0;
      byte_beats.push_back(beat);
   endfunction

   // Move on to the next block, and to the next macroblock after block five.
   function automatic void next_block();
      blk_idx++;
      if (blk_idx >= BLOCKS_PER_MB) begin
         blk_idx = '0;
         mb_idx++;
         if (mb_idx >= MB_TOTAL) grid_full = 1'b1;
         parse_state = AT_HEADER;
         mask_count  = '0;
      end else begin
         parse_state = (mb_mode == MODE_BLOCK_FLAG) ? AT_HEADER : AT_DECIDE;
      end
   endfunction

   function automatic void open_block();
      parse_state = AT_PREFIX;
      tree_node   = '0;
      coef_idx    = '0;
   endfunction

   // The first coefficient of a luma block feeds the running DC sum.
   function automatic void close_coef(input logic signed [8:0] value);
      if (blk_idx < LUMA_BLOCKS && coef_idx == 0) dc_sum = dc_sum + {{9{value[8]}}, value};
      add_beat(KIND_COEF, coef_idx[5:0], value);
      coef_idx++;
      if (coef_idx >= COEFS_PER_BLOCK) begin
         next_block();
      end else begin
         parse_state = AT_PREFIX;
         tree_node   = '0;
      end
   endfunction

   function automatic void size_decoded(input int size);
      if (size == 0) begin
         close_coef('0);
         return;
      end
      amp_size    = size[3:0];
      amp_bits    = '0;
      amp_left    = size[3:0];
      parse_state = AT_AMPLITUDE;
   endfunction

   // One bit of a coefficient: walk the size prefix tree, then gather amplitude bits.
   function automatic void coef_step(input logic b);
      int width;
      int level;
      if (parse_state == AT_PREFIX) begin
         case (tree_node)
            3'd0: tree_node = b ? 3'd2 : 3'd1;
            3'd1: size_decoded(b ? 2 : 1);
            3'd2: tree_node = b ? 3'd4 : 3'd3;
            3'd3: size_decoded(b ? 3 : 0);
            3'd4: if (b) tree_node = 3'd5; else size_decoded(4);
            3'd5: if (b) tree_node = 3'd6; else size_decoded(5);
            3'd6: if (b) tree_node = 3'd7; else size_decoded(6);
            default: size_decoded(b ? 8 : 7);
         endcase
      end else if (parse_state == AT_AMPLITUDE) begin
         amp_bits = {amp_bits[6:0], b};
         if (amp_left > 0) amp_left--;
         if (amp_left == 0) begin
            width = (amp_size < 1) ? 1 : (amp_size > 8) ? 8 : int'(amp_size);
            level = int'(amp_bits);
            // Amplitudes in the lower half stand for negative values.
            if (level < (1 << (width - 1))) level = level - (1 << width) + 1;
            close_coef(level[8:0]);
         end
      end
   endfunction

   // One bit of a block flag, a macroblock flag or a coded pattern.
   function automatic void header_step(input logic b);
      if (blk_idx == 0 && mask_count == 0)
         mb_mode = (mode_setting == MODE_ALIAS) ? MODE_BLOCK_FLAG : mode_setting;
      if (mb_mode == MODE_BLOCK_FLAG) begin
         if (b) begin
            open_block();
         end else begin
            add_beat(KIND_SKIP, '0, '0);
            next_block();
         end
      end else if (mb_mode == MODE_MB_FLAG) begin
         if (b) begin
            coded_mask  = 6'h3F;
            parse_state = AT_DECIDE;
         end else begin
            add_beat(KIND_SKIP, '0, '0);
            blk_idx = 3'd5;
            next_block();
         end
      end else begin
         coded_mask = {coded_mask[4:0], b};
         mask_count++;
         if (mask_count >= 6) begin
            mask_count  = '0;
            parse_state = AT_DECIDE;
         end
      end
   endfunction

   // Blocks left out by the pattern are reported as skips right away.
   function automatic void settle_pattern();
      while (!grid_full && parse_state == AT_DECIDE) begin
         if (coded_mask[3'd5 - blk_idx]) begin
            open_block();
         end else begin
            add_beat(KIND_SKIP, '0, '0);
            next_block();
         end
      end
   endfunction

   // Work out the beats caused by one byte and queue them as awaited.
   function automatic void decode_byte(input logic [7:0] value, input logic last);
      int guard;
      vbcd_result_type beat;
      byte_beats.delete();
      for (int i = 7; i >= 0; i--) begin
         if (grid_full) break;
         if (parse_state == AT_HEADER) header_step(value[i]);
         else if (parse_state == AT_PREFIX || parse_state == AT_AMPLITUDE) coef_step(value[i]);
         settle_pattern();
      end
      if (last) begin
         // A code already begun is finished with zero bits; a partial header is dropped.
         guard = 0;
         while (!grid_full && guard < 16 &&
                ((parse_state == AT_PREFIX && tree_node != 0) || parse_state == AT_AMPLITUDE)) begin
            coef_step(1'b0);
            guard++;
         end
         add_beat(KIND_END, '0, '0);
         restart_frame();
      end
      if (byte_beats.size() > 0) begin
         beat = byte_beats.pop_back();
         beat.last_of_run = 1'b1;
         byte_beats.push_back(beat);
      end
      foreach (byte_beats[k]) awaited_beats.push_back(byte_beats[k]);
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic string beat_text(input vbcd_result_type r);
      return $sformatf("kind %0d mb %0d blk %0d coef %0d value %0d sum %0d last %0d",
                       r.item_kind, r.macroblock_number, r.block_number, r.coef_number,
                       $signed(r.coef_value), $signed(r.luma_dc_sum), r.last_of_run);
   endfunction

   // Each accepted result beat is compared with the oldest awaited one.
   always @(posedge clock) begin : check_beats
      vbcd_result_type want;
      vbcd_result_type got;
      if (!reset && pop && !empty) begin
         got.item_kind         = rsp_item_kind;
         got.macroblock_number = rsp_macroblock_number;
         got.block_number      = rsp_block_number;
         got.coef_number       = rsp_coef_number;
         got.coef_value        = rsp_coef_value;
         got.luma_dc_sum       = rsp_luma_dc_sum;
         got.last_of_run       = rsp_last_of_run;
         if (awaited_beats.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("tb_top: beat with none awaited: %s", beat_text(got));
         end else begin
            want = awaited_beats.pop_front();
            if (want.item_kind !== got.item_kind ||
                want.macroblock_number !== got.macroblock_number ||
                want.block_number !== got.block_number ||
                want.coef_number !== got.coef_number ||
                want.coef_value !== got.coef_value ||
                want.luma_dc_sum !== got.luma_dc_sum ||
                want.last_of_run !== got.last_of_run) begin
               error_count++;
               if (error_count <= 10)
                  $display("tb_top: beat mismatch\n   expected %s\n   actual   %s",
                           beat_text(want), beat_text(got));
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Result side: pop in random bursts of stalls and takes, steady at the end.
   initial begin : pop_driver
      pop <= 1'b0;
      forever begin
         if (steady_flow || $urandom_range(0, 2) != 0) pop <= 1'b1;
         else pop <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic bit one_in(input int n);
      return (n > 0) && ($urandom_range(1, n) == 1);
   endfunction

   function automatic void put_bits(input logic [31:0] value, input int count);
      for (int i = count - 1; i >= 0; i--) stream_bits.push_back(value[i]);
   endfunction

   function automatic void put_coef(input int size, input logic [7:0] amp);
      case (size)
         0: put_bits(3'b100, 3);
         1: put_bits(2'b00, 2);
         2: put_bits(2'b01, 2);
         3: put_bits(3'b101, 3);
         4: put_bits(3'b110, 3);
         5: put_bits(4'b1110, 4);
         6: put_bits(5'b11110, 5);
         7: put_bits(6'b111110, 6);
         default: put_bits(6'b111111, 6);
      endcase
      if (size > 0) put_bits(amp, size);
   endfunction

   function automatic void put_block();
      repeat (COEFS_PER_BLOCK) put_coef($urandom_range(0, 8), 8'($urandom));
   endfunction

   // A well-formed frame for the given mode, built until the bit budget is met.
   function automatic void build_frame(input logic [1:0] mode, input int budget_bits,
                                       input bit skip_only);
      int         mb;
      int         odds;
      bit         flag;
      logic [5:0] mask;
      odds = skip_only ? 0 : 4;
      mb = 0;
      while (mb < MB_TOTAL && stream_bits.size() < budget_bits) begin
         if (mode == MODE_MB_FLAG) begin
            flag = one_in(odds);
            put_bits(flag, 1);
            if (flag) repeat (6) put_block();
         end else if (mode == MODE_PATTERN) begin
            for (int k = 0; k < 6; k++) mask[k] = skip_only ? 1'b0 : one_in(6);
            put_bits(mask, 6);
            for (int k = 5; k >= 0; k--) if (mask[k]) put_block();
         end else begin
            for (int k = 0; k < 6; k++) begin
               flag = one_in(odds);
               put_bits(flag, 1);
               if (flag) put_block();
            end
         end
         mb++;
      end
   endfunction

   // Send one byte; it is predicted once the beat is accepted.
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (!steady_flow && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      push <= 1'b1;
      req_stream_byte <= value;
      req_final_byte <= last;
      do @(posedge clock); while (full);
      decode_byte(value, last);
      bytes_sent++;
   endtask

   // Pack the queued bits into bytes, zero padded; mark the last one final if asked.
   task automatic send_stream(input bit finish);
      logic [7:0] value;
      value = '0;
      while (stream_bits.size() > 0) begin
         for (int k = 0; k < 8; k++)
            value = {value[6:0], (stream_bits.size() > 0) ? stream_bits.pop_front() : 1'b0};
         send_byte(value, finish && stream_bits.size() == 0);
      end
   endtask

   // Wait until every awaited beat has come and the block has had time to go quiet.
   task automatic wait_idle();
      push <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      csr_valid <= 1'b1;
      csr_pattern_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_setting = mode;
   endtask

   // Every size code, the amplitude extremes and a code cut short by the final byte.
   task automatic test_coefficient_codes();
      write_mode(MODE_BLOCK_FLAG);
      put_bits(1'b0, 1);
      put_bits(1'b1, 1);
      put_coef(8, 8'hFF);
      put_coef(8, 8'h00);
      put_coef(0, 8'h00);
      put_coef(1, 8'h00);
      put_coef(1, 8'h01);
      put_coef(2, 8'h02);
      put_coef(3, 8'h03);
      put_coef(4, 8'h0A);
      put_coef(5, 8'h15);
      put_coef(6, 8'h1B);
      put_coef(7, 8'h40);
      put_bits(4'b1111, 4);
      send_stream(1'b1);
      wait_idle();
   endtask

   // Whole grid skipped by macroblock flags; the bits after it are ignored.
   task automatic test_grid_complete();
      write_mode(MODE_MB_FLAG);
      put_bits(32'd0, 24);
      put_bits(32'd0, 24);
      put_bits(32'd0, 24);
      put_bits($urandom, 8);
      send_stream(1'b1);
      wait_idle();
   endtask

   // Skips implied by patterns, also a pattern that ends the stream.
   task automatic test_pattern_skips();
      write_mode(MODE_PATTERN);
      put_bits(6'b000000, 6);
      put_bits(6'b000001, 6);
      put_coef(2, 8'h03);
      put_bits(1'b1, 1);
      send_stream(1'b1);
      put_bits(6'b000000, 6);
      put_bits(2'b01, 2);
      send_stream(1'b1);
      wait_idle();
   endtask

   // Mode three acts as mode zero; a change mid-frame waits for the next macroblock.
   task automatic test_mode_changes();
      write_mode(MODE_ALIAS);
      put_bits(8'h00, 8);
      send_stream(1'b0);
      wait_idle();
      write_mode(MODE_MB_FLAG);
      put_bits(8'h00, 8);
      send_stream(1'b1);
      wait_idle();
   endtask

   // Random frames: mostly well formed and cut at a random length, some pure noise.
   task automatic test_random_frames();
      int         first;
      int         budget;
      bit         skip_only;
      logic [1:0] mode;
      first = bytes_sent;
      mode = mode_setting;
      while (bytes_sent - first < RANDOM_BYTES) begin
         if (bytes_sent - first >= STEADY_AFTER) steady_flow = 1'b1;
         if ($urandom_range(0, 1) == 0) begin
            wait_idle();
            mode = one_in(10) ? MODE_ALIAS : 2'($urandom_range(0, 2));
            write_mode(mode);
         end
         if (one_in(6)) begin
            budget = $urandom_range(1, 12);
            repeat (budget * 8) stream_bits.push_back(1'($urandom));
         end else begin
            skip_only = one_in(4);
            if (!skip_only) budget = $urandom_range(1, 40);
            else if (mode == MODE_MB_FLAG) budget = $urandom_range(9, 14);
            else budget = $urandom_range(9, 60);
            build_frame(mode, budget * 8, skip_only);
            while (stream_bits.size() > budget * 8) void'(stream_bits.pop_back());
            while (stream_bits.size() < budget * 8) stream_bits.push_back(1'($urandom));
         end
         send_stream(1'b1);
      end
   endtask

   // Reset, then the tests in turn.
   initial begin : run_tests
      push <= 1'b0;
      req_stream_byte <= '0;
      req_final_byte <= 1'b0;
      csr_valid <= 1'b0;
      csr_pattern_mode <= '0;
      reset <= 1'b1;
      mode_setting = MODE_BLOCK_FLAG;
      restart_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_coefficient_codes();
      test_grid_complete();
      test_pattern_skips();
      test_mode_changes();
      test_random_frames();
      wait_idle();
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
